@@ rtl/core/dipv4_pkg.sv @@
// Package for the dotted IPv4 text parser: parse state type and character codes.
// Used by dipv4_step, dotted_ipv4_text_parser, dipv4_address_checker and the test; depends on nothing.

package dipv4_pkg;

   // Parse state carried from one character to the next
   typedef struct packed {
      logic [7:0]  octet_accum;      // value of the current part, modulo 256
      logic [1:0]  part_char_count;  // characters in the current part, saturates at 2
      logic        hex_mode;         // current part is hexadecimal
      logic [1:0]  octet_index;      // number of the current part
      logic [23:0] done_octets;      // finished parts 0..2
      logic        error_seen;
      logic        stopped;
   } parse_state_type;

   localparam parse_state_type PARSE_STATE_RESET = '0;

   // Character codes
   localparam logic [7:0] CHAR_NUL   = 8'h00;
   localparam logic [7:0] CHAR_DOT   = 8'h2E;
   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_NINE  = 8'h39;
   localparam logic [7:0] CHAR_UP_A  = 8'h41;
   localparam logic [7:0] CHAR_UP_F  = 8'h46;
   localparam logic [7:0] CHAR_LOW_A = 8'h61;
   localparam logic [7:0] CHAR_LOW_F = 8'h66;
   localparam logic [7:0] CHAR_UP_X  = 8'h58;
   localparam logic [7:0] CHAR_LOW_X = 8'h78;

   localparam logic [7:0] HEX_TEN    = 8'h0A;
   localparam logic [1:0] LAST_PART  = 2'd3;
   localparam logic [1:0] COUNT_SAT  = 2'd2;

endpackage

@@ rtl/core/dotted_ipv4_text_parser.sv @@
// Top level of the dotted IPv4 text parser: input register, parse step, result register.
// Depends on dipv4_pkg and dipv4_step.

// The block reads an IPv4 address string one character per word on the req_ stream,
// the last character marked by req_tlast, and returns one word on the rsp_ stream
// per string: the 32-bit address with the first octet in bits 7:0 and, in tuser, an
// error flag. Parts are decimal, or hexadecimal after a "0x"/"0X" prefix, and wrap
// modulo 256; missing parts read as zero. A bad character or a fourth dot gives all
// ones with the error flag set. A NUL, or any character past the first MAX_CHARS,
// ends parsing and the rest of the string is skipped up to tlast. Rate: one
// character per clock cycle, set by the combinational parse step that folds each
// character into the state, except that a final character waits while a result is
// still untaken. The last character passes through the input register and then, once
// the result register is free, into it; rsp_ is driven from the result register.
// Both sides may stall freely; the input register keeps taking words while a result
// waits to be taken, until a further end-of-string word would overrun it.

module dotted_ipv4_text_parser #(
   parameter int MAX_CHARS = 16
) (
   input  logic        clock,
   input  logic        reset,
   // input characters
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] text_char
   input  logic        req_tlast,   // end_of_string
   // parsed addresses
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // [31:0] ip_address
   output logic        rsp_tuser    // [0] parse_error
);

   localparam int CNT_W = $clog2(MAX_CHARS + 1);

   // input register
   logic                       in_valid_ff, in_valid_in;
   logic [7:0]                 in_char_ff, in_char_in;
   logic                       in_last_ff, in_last_in;

   // parse state
   dipv4_pkg::parse_state_type state_ff, state_in;
   logic [CNT_W-1:0]           chars_ff, chars_in;

   // result register
   logic                       out_valid_ff, out_valid_in;
   logic [31:0]                out_addr_ff, out_addr_in;
   logic                       out_err_ff, out_err_in;

   dipv4_pkg::parse_state_type step_state;
   logic [CNT_W-1:0]           step_chars;
   logic [31:0]                step_addr;
   logic                       step_err;
   logic                       out_free;
   logic                       advance;
   logic                       req_take;

   dipv4_step #(
      .MAX_CHARS (MAX_CHARS)
   ) u_step (
      .cur_state   (state_ff),
      .cur_chars   (chars_ff),
      .text_char   (in_char_ff),
      .nxt_state   (step_state),
      .nxt_chars   (step_chars),
      .ip_address  (step_addr),
      .parse_error (step_err)
   );

   // A character with no result always moves on; the final one waits for a free slot
   assign out_free   = !out_valid_ff || rsp_tready;
   assign advance    = in_valid_ff && (!in_last_ff || out_free);
   assign req_tready = !in_valid_ff || advance;
   assign req_take   = req_tvalid && req_tready;

   always_comb begin
      in_valid_in = in_valid_ff;
      in_char_in  = in_char_ff;
      in_last_in  = in_last_ff;
      if (advance) begin
         in_valid_in = 1'b0;
      end
      if (req_take) begin
         in_valid_in = 1'b1;
         in_char_in  = req_tdata;
         in_last_in  = req_tlast;
      end
   end

   always_comb begin
      state_in = state_ff;
      chars_in = chars_ff;
      if (advance) begin
         if (in_last_ff) begin
            // string finished: back to a clean state for the next one
            state_in = dipv4_pkg::PARSE_STATE_RESET;
            chars_in = '0;
         end else begin
            state_in = step_state;
            chars_in = step_chars;
         end
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      out_addr_in  = out_addr_ff;
      out_err_in   = out_err_ff;
      if (rsp_tready) begin
         out_valid_in = 1'b0;
      end
      if (advance && in_last_ff) begin
         out_valid_in = 1'b1;
         out_addr_in  = step_addr;
         out_err_in   = step_err;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         state_ff     <= dipv4_pkg::PARSE_STATE_RESET;
         chars_ff     <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         state_ff     <= state_in;
         chars_ff     <= chars_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      in_char_ff  <= in_char_in;
      in_last_ff  <= in_last_in;
      out_addr_ff <= out_addr_in;
      out_err_ff  <= out_err_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_addr_ff;
   assign rsp_tuser  = out_err_ff;

endmodule

@@ rtl/core/dipv4_step.sv @@
// Next-state logic of the dotted IPv4 text parser for one character.
// Depends on dipv4_pkg.

module dipv4_step #(
   parameter int MAX_CHARS = 16,
   localparam int CNT_W = $clog2(MAX_CHARS + 1)
) (
   input  dipv4_pkg::parse_state_type cur_state,
   input  logic [CNT_W-1:0]           cur_chars,
   input  logic [7:0]                 text_char,
   output dipv4_pkg::parse_state_type nxt_state,
   output logic [CNT_W-1:0]           nxt_chars,
   output logic [31:0]                ip_address,
   output logic                       parse_error
);

   logic        is_digit;
   logic        is_upper_hex;
   logic        is_lower_hex;
   logic [7:0]  digit_val;
   logic [7:0]  upper_val;
   logic [7:0]  lower_val;
   logic [7:0]  accum_times_ten;
   logic [7:0]  accum_shifted;
   logic [1:0]  count_bumped;
   logic [31:0] assembled;

   assign is_digit     = (text_char >= dipv4_pkg::CHAR_ZERO) &&
                         (text_char <= dipv4_pkg::CHAR_NINE);
   assign is_upper_hex = (text_char >= dipv4_pkg::CHAR_UP_A) &&
                         (text_char <= dipv4_pkg::CHAR_UP_F);
   assign is_lower_hex = (text_char >= dipv4_pkg::CHAR_LOW_A) &&
                         (text_char <= dipv4_pkg::CHAR_LOW_F);

   assign digit_val = text_char - dipv4_pkg::CHAR_ZERO;
   assign upper_val = text_char - dipv4_pkg::CHAR_UP_A + dipv4_pkg::HEX_TEN;
   assign lower_val = text_char - dipv4_pkg::CHAR_LOW_A + dipv4_pkg::HEX_TEN;

   // times ten as two shifts and an add, wrapping at 8 bits
   assign accum_times_ten = {cur_state.octet_accum[4:0], 3'b000} +
                            {cur_state.octet_accum[6:0], 1'b0};
   assign accum_shifted   = {cur_state.octet_accum[3:0], 4'h0};

   assign count_bumped = (cur_state.part_char_count < dipv4_pkg::COUNT_SAT) ?
                         cur_state.part_char_count + 2'd1 :
                         cur_state.part_char_count;

   always_comb begin
      nxt_state = cur_state;
      nxt_chars = cur_chars;
      if (!cur_state.stopped && !cur_state.error_seen) begin
         if ((cur_chars >= CNT_W'(MAX_CHARS)) || (text_char == dipv4_pkg::CHAR_NUL)) begin
            nxt_state.stopped = 1'b1;
         end else begin
            nxt_chars = cur_chars + CNT_W'(1);
            if (text_char == dipv4_pkg::CHAR_DOT) begin
               if (cur_state.octet_index == dipv4_pkg::LAST_PART) begin
                  nxt_state.error_seen = 1'b1;
               end else begin
                  nxt_state.done_octets = cur_state.done_octets |
                     (24'(cur_state.octet_accum) << {cur_state.octet_index, 3'b000});
                  nxt_state.octet_index     = cur_state.octet_index + 2'd1;
                  nxt_state.octet_accum     = '0;
                  nxt_state.part_char_count = '0;
                  nxt_state.hex_mode        = 1'b0;
               end
            end else if (is_digit) begin
               nxt_state.octet_accum = (cur_state.hex_mode ? accum_shifted : accum_times_ten) +
                                       digit_val;
               nxt_state.part_char_count = count_bumped;
            end else if (cur_state.hex_mode) begin
               if (is_upper_hex) begin
                  nxt_state.octet_accum     = accum_shifted + upper_val;
                  nxt_state.part_char_count = count_bumped;
               end else if (is_lower_hex) begin
                  nxt_state.octet_accum     = accum_shifted + lower_val;
                  nxt_state.part_char_count = count_bumped;
               end else begin
                  nxt_state.error_seen = 1'b1;
               end
            end else if ((text_char == dipv4_pkg::CHAR_LOW_X) ||
                         (text_char == dipv4_pkg::CHAR_UP_X)) begin
               // switch to hex only for a "0x" prefix, otherwise drop the x
               if ((cur_state.octet_accum == 8'h00) && (cur_state.part_char_count == 2'd1)) begin
                  nxt_state.hex_mode = 1'b1;
               end
               nxt_state.part_char_count = count_bumped;
            end else begin
               nxt_state.error_seen = 1'b1;
            end
         end
      end
   end

   // Result from the state after this character
   assign assembled = {8'h00, nxt_state.done_octets} |
                      (32'(nxt_state.octet_accum) << {nxt_state.octet_index, 3'b000});

   assign ip_address  = nxt_state.error_seen ? 32'hFFFF_FFFF : assembled;
   assign parse_error = nxt_state.error_seen;

endmodule

@@ tb/dipv4_address_checker.sv @@
// Checker for the dotted IPv4 text parser: watches both streams, folds accepted
// characters into its own parse state and compares each address word taken on rsp_.
// Depends on dipv4_pkg for the parse state type and character codes.

module dipv4_address_checker #(
   parameter int MAX_CHARS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] text_char
   input  logic        req_tlast,   // end_of_string
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [31:0] rsp_tdata,   // [31:0] ip_address
   input  logic        rsp_tuser,   // [0] parse_error
   output int          mismatch_count,
   output int          pending_addresses
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [31:0] ip_address;
      logic        parse_error;
   } address_word_type;

   address_word_type           expected_addresses[$];
   dipv4_pkg::parse_state_type text_state;
   logic [4:0]                 chars_parsed;

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      if (mismatch_count < 40) begin
         $display("%0t: address mismatch on %s: got %h, want %h", $realtime, what, got, want);
      end
      mismatch_count++;
   endtask

   // Fold one character into the parse state; stop or error freezes it until tlast.
   function automatic void fold_char(input logic [7:0] c);
      logic [7:0] nibble;
      if (chars_parsed >= MAX_CHARS || c == dipv4_pkg::CHAR_NUL) begin
         text_state.stopped = 1'b1;
         return;
      end
      chars_parsed = chars_parsed + 5'd1;
      if (c == dipv4_pkg::CHAR_DOT) begin
         if (text_state.octet_index >= dipv4_pkg::LAST_PART) begin
            text_state.error_seen = 1'b1;
            return;
         end
         text_state.done_octets = text_state.done_octets
            | (24'(text_state.octet_accum) << (8 * text_state.octet_index));
         text_state.octet_index     = text_state.octet_index + 2'd1;
         text_state.octet_accum     = '0;
         text_state.part_char_count = '0;
         text_state.hex_mode        = 1'b0;
         return;
      end
      if (c >= dipv4_pkg::CHAR_ZERO && c <= dipv4_pkg::CHAR_NINE) begin
         if (text_state.hex_mode) begin
            text_state.octet_accum = {text_state.octet_accum[3:0], 4'h0};
         end else begin
            text_state.octet_accum = text_state.octet_accum * 8'd10;
         end
         text_state.octet_accum = text_state.octet_accum + (c - dipv4_pkg::CHAR_ZERO);
      end else if (text_state.hex_mode) begin
         if (c >= dipv4_pkg::CHAR_UP_A && c <= dipv4_pkg::CHAR_UP_F) begin
            nibble = c - dipv4_pkg::CHAR_UP_A + dipv4_pkg::HEX_TEN;
         end else if (c >= dipv4_pkg::CHAR_LOW_A && c <= dipv4_pkg::CHAR_LOW_F) begin
            nibble = c - dipv4_pkg::CHAR_LOW_A + dipv4_pkg::HEX_TEN;
         end else begin
            text_state.error_seen = 1'b1;
            return;
         end
         text_state.octet_accum = {text_state.octet_accum[3:0], nibble[3:0]};
      end else if (c == dipv4_pkg::CHAR_LOW_X || c == dipv4_pkg::CHAR_UP_X) begin
         // only "0x" at the head of a part switches radix; elsewhere skip it
         if (text_state.octet_accum == 8'd0 && text_state.part_char_count == 2'd1) begin
            text_state.hex_mode = 1'b1;
         end
      end else begin
         text_state.error_seen = 1'b1;
         return;
      end
      if (text_state.part_char_count < dipv4_pkg::COUNT_SAT) begin
         text_state.part_char_count = text_state.part_char_count + 2'd1;
      end
   endfunction

   always @(posedge clock) begin
      address_word_type want;
      address_word_type finished;
      if (reset) begin
         text_state = dipv4_pkg::PARSE_STATE_RESET;
         chars_parsed = '0;
         expected_addresses.delete();
         mismatch_count = 0;
      end else begin
         // take results first: a word accepted now cannot be answered at this edge
         if (rsp_tvalid && rsp_tready) begin
            if (expected_addresses.size() == 0) begin
               report_mismatch("unexpected word", rsp_tdata, '0);
            end else begin
               want = expected_addresses.pop_front();
               if (rsp_tdata !== want.ip_address) begin
                  report_mismatch("ip_address", rsp_tdata, want.ip_address);
               end
               if (rsp_tuser !== want.parse_error) begin
                  report_mismatch("parse_error", 32'(rsp_tuser), 32'(want.parse_error));
               end
            end
         end
         if (req_tvalid && req_tready) begin
            if (!text_state.stopped && !text_state.error_seen) begin
               fold_char(req_tdata);
            end
            if (req_tlast) begin
               if (text_state.error_seen) begin
                  finished.ip_address  = '1;
                  finished.parse_error = 1'b1;
               end else begin
                  finished.ip_address = {8'h00, text_state.done_octets}
                     | (32'(text_state.octet_accum) << (8 * text_state.octet_index));
                  finished.parse_error = 1'b0;
               end
               expected_addresses.push_back(finished);
               text_state = dipv4_pkg::PARSE_STATE_RESET;
               chars_parsed = '0;
            end
         end
      end
      pending_addresses <= expected_addresses.size();
   end

endmodule

@@ tb/dotted_ipv4_text_parser_test.sv @@
// Testbench top for the dotted IPv4 text parser: clock, reset, character stimulus,
// random stalls on both streams and the verdict.
// Depends on dipv4_pkg, dotted_ipv4_text_parser and dipv4_address_checker.

module dotted_ipv4_text_parser_test;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int RANDOM_WORDS  = 1950;
   localparam int HOLD_CYCLES   = 300;
   localparam int SETTLE_CYCLES = 10;
   localparam int QUIET_FROM    = 800;   // words into the random part where idling stops
   localparam int QUIET_TO      = 1100;  // and where it resumes

   logic        clock = 1'b0;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [7:0]  req_tdata;   // [7:0] text_char
   logic        req_tlast;   // end_of_string
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [31:0] rsp_tdata;   // [31:0] ip_address
   logic        rsp_tuser;   // [0] parse_error
   int          mismatch_count;
   int          pending_addresses;

   bit          quiet;          // no idling on either side while set
   bit          hold_request;   // ask the receiver for one long hold-off
   logic [7:0]  text_q[$];      // string being built for the next send
   int          random_words_sent;

   dotted_ipv4_text_parser DUT (.*);

   dipv4_address_checker address_checker (.*);

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Generous cap on the whole run; a hang or a lost result ends here.
   initial begin
      #2_000_000;
      $display("TB_ERROR");
      $finish;
   end

   // Receiver: random back-pressure, one long hold-off on request.
   initial begin
      bit hold_done;
      hold_done  = 1'b0;
      rsp_tready = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (hold_request && !hold_done) begin
            hold_done = 1'b1;
            rsp_tready <= 1'b0;
            // hold for a counted stretch so the block fills and stalls req_
            repeat (HOLD_CYCLES) @(negedge clock);
         end
         rsp_tready <= quiet || ($urandom_range(99) >= 15);
         @(negedge clock);
      end
   end

   // Offer one word; maybe idle first, then hold it until the handshake.
   task automatic send_word(input logic [7:0] c, input logic last);
      @(negedge clock);
      if (!quiet && $urandom_range(99) < 6) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= c;
      req_tlast  <= last;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   task automatic send_text(input string s);
      for (int i = 0; i < s.len(); i++) begin
         send_word(s[i], i == s.len() - 1);
      end
   endtask

   // Send the built string, tlast on its final character.
   task automatic send_queue();
      foreach (text_q[i]) begin
         send_word(text_q[i], i == text_q.size() - 1);
      end
      random_words_sent += text_q.size();
   endtask

   // Append a plausible address: one to four parts, sometimes a fifth, mixed radix.
   task automatic add_address();
      int parts;
      int digits;
      int v;
      parts = ($urandom_range(9) == 0) ? 5 : $urandom_range(1, 4);
      for (int p = 0; p < parts; p++) begin
         if (p > 0) text_q.push_back(dipv4_pkg::CHAR_DOT);
         if ($urandom_range(3) == 0) begin
            text_q.push_back(dipv4_pkg::CHAR_ZERO);
            text_q.push_back($urandom_range(1) ? dipv4_pkg::CHAR_LOW_X : dipv4_pkg::CHAR_UP_X);
            digits = $urandom_range(0, 3);
            repeat (digits) begin
               v = $urandom_range(15);
               if (v < 10) begin
                  text_q.push_back(dipv4_pkg::CHAR_ZERO + 8'(v));
               end else begin
                  text_q.push_back(($urandom_range(1) ? dipv4_pkg::CHAR_LOW_A :
                                    dipv4_pkg::CHAR_UP_A) + 8'(v - 10));
               end
            end
         end else begin
            digits = $urandom_range(0, 3);
            for (int d = 0; d < digits; d++) begin
               text_q.push_back(dipv4_pkg::CHAR_ZERO + 8'($urandom_range(9)));
               // a stray x after the first digit: prefix when it follows a zero
               if (d == 0 && $urandom_range(9) == 0) begin
                  text_q.push_back($urandom_range(1) ? dipv4_pkg::CHAR_LOW_X :
                                   dipv4_pkg::CHAR_UP_X);
               end
            end
         end
      end
   endtask

   task automatic add_noise();
      string pool;
      pool = "0123456789.xXaFg";
      repeat ($urandom_range(1, 20)) begin
         if ($urandom_range(1)) begin
            text_q.push_back(pool[$urandom_range(pool.len() - 1)]);
         end else begin
            text_q.push_back(8'($urandom_range(255)));
         end
      end
   endtask

   initial begin
      int kind;
      reset        = 1'b1;
      req_tvalid   = 1'b0;
      req_tdata    = '0;
      req_tlast    = 1'b0;
      quiet        = 1'b0;
      hold_request = 1'b0;
      random_words_sent = 0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed: hex prefix with upper X and lower digit, fourth dot, stray x in
      // decimal, bad hex digit, bad character, NUL stop, empty parts, octet wrap.
      send_text("0Xf.");
      send_text("1.2.3.4.");
      send_text("1x9");
      send_text("0xg");
      send_text("#");
      send_word(dipv4_pkg::CHAR_NUL, 1'b0);
      send_word(dipv4_pkg::CHAR_ZERO + 8'd5, 1'b1);
      send_text("...");
      send_text("999");
      send_word(8'hFF, 1'b1);

      // Pressure: the receiver holds off while whole addresses keep coming.
      hold_request = 1'b1;
      repeat (6) begin
         text_q.delete();
         add_address();
         if (text_q.size() == 0) text_q.push_back(dipv4_pkg::CHAR_ZERO);
         send_queue();
      end
      random_words_sent = 0;

      // Random: mostly well-formed addresses, mixed with noise and corrupted addresses.
      while (random_words_sent < RANDOM_WORDS) begin
         quiet = (random_words_sent >= QUIET_FROM && random_words_sent < QUIET_TO);
         text_q.delete();
         kind = $urandom_range(99);
         if (kind < 70) begin
            add_address();
         end else if (kind < 85) begin
            add_noise();
         end else begin
            add_address();
            if (text_q.size() == 0) text_q.push_back(dipv4_pkg::CHAR_ZERO);
            text_q[$urandom_range(text_q.size() - 1)] = 8'($urandom_range(255));
         end
         if (text_q.size() == 0) begin
            text_q.push_back(dipv4_pkg::CHAR_ZERO + 8'($urandom_range(9)));
         end
         send_queue();
      end
      quiet = 1'b0;

      @(negedge clock);
      req_tvalid <= 1'b0;

      // Drain: wait for every address word, then let the pipeline settle.
      while (pending_addresses != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule

@@ dotted_ipv4_text_parser.f @@
rtl/core/dipv4_pkg.sv
rtl/core/dipv4_step.sv
rtl/core/dotted_ipv4_text_parser.sv
tb/dipv4_address_checker.sv
tb/dotted_ipv4_text_parser_test.sv
